// File: src/adsr_pkg.sv
// Shared constants, types and codes for the ADSR envelope generator.
package adsr_pkg;

    localparam int LEVEL_FRAC_BITS = 16;
    localparam int TIME_BITS       = 24;
    localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
    localparam int ELAPSED_W       = TIME_BITS + 1;
    localparam int MIN_TIME_W      = 16;
    localparam int FRAME_W         = 16;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W0     = (TIME_BITS > LEVEL_W) ? TIME_BITS : LEVEL_W;
    localparam int CFG_DATA_W      = (CFG_DATA_W0 > MIN_TIME_W) ? CFG_DATA_W0 : MIN_TIME_W;
    localparam int PROD_W          = LEVEL_W + TIME_BITS;
    localparam int DIV_CNT_W       = $clog2(LEVEL_W);
    localparam int CMP_W           = 33;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    localparam logic [TIME_BITS-1:0]  ATTACK_RST   = TIME_BITS'(4800);
    localparam logic [TIME_BITS-1:0]  DECAY_RST    = TIME_BITS'(9600);
    localparam logic [LEVEL_W-1:0]    SUSTAIN_RST  = LEVEL_W'(45875);
    localparam logic [TIME_BITS-1:0]  RELEASE_RST  = TIME_BITS'(14400);
    localparam logic [MIN_TIME_W-1:0] MIN_TIME_RST = MIN_TIME_W'(48);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        OP_PROCESS  = 2'd0,
        OP_GATE_ON  = 2'd1,
        OP_GATE_OFF = 2'd2,
        OP_RESET    = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ATTACK   = 3'd0,
        CFG_DECAY    = 3'd1,
        CFG_SUSTAIN  = 3'd2,
        CFG_RELEASE  = 3'd3,
        CFG_MIN_TIME = 3'd4
    } cfg_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHECK,
        ST_WAIT,
        ST_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic                 start;
        logic [LEVEL_W-1:0]   mult;
        logic [TIME_BITS-1:0] multiplicand;
        logic [TIME_BITS-1:0] divisor;
    } md_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } md_rsp_t;

endpackage

// File: src/adsr_muldiv.sv
// Multiply then restoring divide: floor(mult * multiplicand / divisor), one bit a cycle.
module adsr_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  adsr_pkg::md_req_t req,
    output adsr_pkg::md_rsp_t rsp
);
    import adsr_pkg::*;

    md_state_t              state_reg, state_next;
    logic [LEVEL_W-1:0]     a_reg;
    logic [TIME_BITS-1:0]   b_reg;
    logic [TIME_BITS-1:0]   d_reg;
    logic [PROD_W-1:0]      product;
    logic [TIME_BITS-1:0]   rem_reg, rem_next;
    logic [LEVEL_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [TIME_BITS:0]     trial;
    logic [TIME_BITS:0]     diff;
    logic                   fits;
    logic                   last_step;

    assign product   = PROD_W'(a_reg) * PROD_W'(b_reg);
    // multiplicand never exceeds divisor, so the quotient fits LEVEL_W bits
    // and the upper product bits start below the divisor
    assign trial     = {rem_reg, quo_reg[LEVEL_W-1]};
    assign diff      = trial - {1'b0, d_reg};
    assign fits      = trial >= {1'b0, d_reg};
    assign last_step = cnt_reg == DIV_CNT_W'(LEVEL_W - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                state_next = MD_DIV;
            end
            MD_DIV:
            begin
                if (last_step)
                begin
                    state_next = MD_IDLE;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        unique case (state_reg)
            MD_MUL:
            begin
                rem_next = product[PROD_W-1:LEVEL_W];
                quo_next = product[LEVEL_W-1:0];
                cnt_next = '0;
            end
            MD_DIV:
            begin
                rem_next  = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
                quo_next  = {quo_reg[LEVEL_W-2:0], fits};
                cnt_next  = cnt_reg + DIV_CNT_W'(1);
                done_next = last_step;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MD_IDLE && req.start)
        begin
            a_reg <= req.mult;
            b_reg <= req.multiplicand;
            d_reg <= req.divisor;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: src/adsr_envelope_generator_core.sv
// Top level of the linear ADSR envelope generator: event sequencer, state and config.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+--------------------------
//  in       | input     | in_valid / in_stall   | opcode, frame_count
//  out      | output    | out_valid / out_stall | level, phase_now
//  cfg      | input     | cfg_write             | cfg_index, cfg_data
//
// Gate, reset and idle/sustain events go from accept through ST_EVAL to ST_OUT.
// Ramp events pass ST_CHECK and ST_WAIT as well: one multiply plus 17 restoring divide
// steps in adsr_muldiv; instant or finished ramps skip ST_WAIT and the divider.
// One event is in work at a time; in_stall is high from accept until done.
// A result waiting on out_stall does not block the next accept.
// Async reset clears state and reloads the default register values.
module adsr_envelope_generator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          opcode,
    input  logic [adsr_pkg::FRAME_W-1:0]        frame_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [adsr_pkg::LEVEL_W-1:0]        level,
    output logic [2:0]                          phase_now,
    input  logic                                cfg_write,
    input  logic [adsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import adsr_pkg::*;

    logic [TIME_BITS-1:0]  attack_reg;
    logic [TIME_BITS-1:0]  decay_reg;
    logic [LEVEL_W-1:0]    sustain_reg;
    logic [TIME_BITS-1:0]  release_reg;
    logic [MIN_TIME_W-1:0] min_time_reg;

    seq_state_t            state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic                  gate_reg, gate_next;

    opcode_t               op_reg;
    logic [FRAME_W-1:0]    frames_reg;

    logic                  out_valid_reg;
    logic [LEVEL_W-1:0]    level_out_reg;
    phase_t                phase_out_reg;

    logic                  in_accept;
    logic                  out_load;
    logic [LEVEL_W-1:0]    sustain_sat;
    logic [ELAPSED_W:0]    elapsed_sum;
    logic [ELAPSED_W-1:0]  elapsed_adv;
    logic [TIME_BITS-1:0]  ramp_len;
    logic                  instant;
    logic                  reached;
    md_req_t               md_req;
    md_rsp_t               md_rsp;

    adsr_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign in_accept   = in_valid && !in_stall;
    assign sustain_sat = (sustain_reg > FULL_SCALE) ? FULL_SCALE : sustain_reg;
    assign elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(frames_reg);
    assign elapsed_adv = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];

    always_comb
    begin
        unique case (phase_reg)
            PH_ATTACK: ramp_len = attack_reg;
            PH_DECAY:  ramp_len = decay_reg;
            default:   ramp_len = release_reg;
        endcase
    end

    assign instant = CMP_W'(ramp_len) <= CMP_W'(min_time_reg);
    assign reached = elapsed_reg >= ELAPSED_W'(ramp_len);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (op_reg == OP_PROCESS &&
                    (phase_reg == PH_ATTACK || phase_reg == PH_DECAY ||
                     phase_reg == PH_RELEASE))
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_CHECK:
            begin
                state_next = (instant || reached) ? ST_OUT : ST_WAIT;
            end
            ST_WAIT:
            begin
                if (md_rsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // envelope state update
    always_comb
    begin
        phase_next   = phase_reg;
        level_next   = level_reg;
        elapsed_next = elapsed_reg;
        gate_next    = gate_reg;
        unique case (state_reg)
            ST_EVAL:
            begin
                unique case (op_reg)
                    OP_GATE_ON:
                    begin
                        gate_next    = 1'b1;
                        phase_next   = PH_ATTACK;
                        elapsed_next = '0;
                    end
                    OP_GATE_OFF:
                    begin
                        gate_next = 1'b0;
                        if (phase_reg != PH_IDLE)
                        begin
                            phase_next   = PH_RELEASE;
                            elapsed_next = '0;
                        end
                    end
                    OP_RESET:
                    begin
                        phase_next   = PH_IDLE;
                        level_next   = '0;
                        elapsed_next = '0;
                        gate_next    = 1'b0;
                    end
                    default:
                    begin
                        unique case (phase_reg)
                            PH_ATTACK, PH_DECAY, PH_RELEASE:
                            begin
                                elapsed_next = elapsed_adv;
                            end
                            PH_SUSTAIN:
                            begin
                                level_next = sustain_sat;
                                if (!gate_reg)
                                begin
                                    phase_next   = PH_RELEASE;
                                    elapsed_next = '0;
                                end
                            end
                            default:
                            begin
                                level_next = '0;
                            end
                        endcase
                    end
                endcase
            end
            ST_CHECK:
            begin
                if (instant || reached)
                begin
                    elapsed_next = '0;
                    unique case (phase_reg)
                        PH_ATTACK:
                        begin
                            level_next = FULL_SCALE;
                            phase_next = PH_DECAY;
                        end
                        PH_DECAY:
                        begin
                            level_next = sustain_sat;
                            phase_next = PH_SUSTAIN;
                        end
                        default:
                        begin
                            level_next = '0;
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            ST_WAIT:
            begin
                if (md_rsp.done)
                begin
                    level_next = (phase_reg == PH_DECAY) ? FULL_SCALE - md_rsp.quotient
                                                         : md_rsp.quotient;
                end
            end
            default:
            begin
            end
        endcase
    end

    // handshake and unit control
    always_comb
    begin
        in_stall = state_reg != ST_IDLE;
        out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

        md_req.start   = (state_reg == ST_CHECK) && !(instant || reached);
        md_req.divisor = ramp_len;
        unique case (phase_reg)
            PH_ATTACK:
            begin
                md_req.mult         = FULL_SCALE;
                md_req.multiplicand = elapsed_reg[TIME_BITS-1:0];
            end
            PH_DECAY:
            begin
                md_req.mult         = FULL_SCALE - sustain_sat;
                md_req.multiplicand = elapsed_reg[TIME_BITS-1:0];
            end
            default:
            begin
                md_req.mult         = sustain_sat;
                md_req.multiplicand = ramp_len - elapsed_reg[TIME_BITS-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg   <= ATTACK_RST;
            decay_reg    <= DECAY_RST;
            sustain_reg  <= SUSTAIN_RST;
            release_reg  <= RELEASE_RST;
            min_time_reg <= MIN_TIME_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel_t'(cfg_index))
                CFG_ATTACK:   attack_reg   <= cfg_data[TIME_BITS-1:0];
                CFG_DECAY:    decay_reg    <= cfg_data[TIME_BITS-1:0];
                CFG_SUSTAIN:  sustain_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_RELEASE:  release_reg  <= cfg_data[TIME_BITS-1:0];
                CFG_MIN_TIME: min_time_reg <= cfg_data[MIN_TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            level_reg     <= '0;
            elapsed_reg   <= '0;
            gate_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            elapsed_reg   <= elapsed_next;
            gate_reg      <= gate_next;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg     <= opcode_t'(opcode);
            frames_reg <= frame_count;
        end
        if (out_load)
        begin
            level_out_reg <= level_reg;
            phase_out_reg <= phase_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_out_reg;
    assign phase_now = phase_out_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> state_reg == ST_WAIT)
        else $error("divider finished outside of wait state");

    a_start_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |=> state_reg == ST_WAIT)
        else $error("divider started but sequencer not waiting");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= FULL_SCALE)
        else $error("level above full scale");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> level_reg == '0)
        else $error("nonzero level in idle phase");

endmodule

// File: tb/sv/adsr_env_checker.sv
// Envelope checker: tracks the channels, predicts each result beat and compares it.
module adsr_env_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [1:0]                       opcode,
    input  logic [adsr_pkg::FRAME_W-1:0]     frame_count,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [adsr_pkg::LEVEL_W-1:0]     level,
    input  logic [2:0]                       phase_now,
    input  logic                             cfg_write,
    input  logic [adsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               pend_count
);
    import adsr_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        phase_t             phase;
    } env_point_t;

    localparam longint unsigned FS_WIDE     = 64'(FULL_SCALE);
    localparam longint unsigned ELAPSED_TOP = (64'd1 << ELAPSED_W) - 64'd1;

    // register copies
    logic [TIME_BITS-1:0]  attack_len;
    logic [TIME_BITS-1:0]  decay_len;
    logic [LEVEL_W-1:0]    sustain_cfg;
    logic [TIME_BITS-1:0]  release_len;
    logic [MIN_TIME_W-1:0] instant_len;

    // envelope state
    phase_t                env_phase;
    logic [LEVEL_W-1:0]    env_level;
    logic [ELAPSED_W-1:0]  env_elapsed;
    logic                  env_gate;

    env_point_t            envelope_q[$];
    env_point_t            want;
    int                    mismatches = 0;

    assign fail_count = mismatches;

    function automatic void step_envelope(opcode_t op, logic [FRAME_W-1:0] fc);
        longint unsigned sus;
        longint unsigned e;
        sus = (sustain_cfg > FULL_SCALE) ? FS_WIDE : 64'(sustain_cfg);
        e = 64'(env_elapsed) + 64'(fc);
        if (e > ELAPSED_TOP)
            e = ELAPSED_TOP;
        case (op)
            OP_PROCESS:
            begin
                case (env_phase)
                    PH_ATTACK:
                    begin
                        if (attack_len <= instant_len || e >= 64'(attack_len))
                        begin
                            env_level = FULL_SCALE;
                            env_phase = PH_DECAY;
                            env_elapsed = '0;
                        end
                        else
                        begin
                            env_level = LEVEL_W'((e * FS_WIDE) / 64'(attack_len));
                            env_elapsed = ELAPSED_W'(e);
                        end
                    end
                    PH_DECAY:
                    begin
                        if (decay_len <= instant_len || e >= 64'(decay_len))
                        begin
                            env_level = LEVEL_W'(sus);
                            env_phase = PH_SUSTAIN;
                            env_elapsed = '0;
                        end
                        else
                        begin
                            env_level = LEVEL_W'(FS_WIDE - ((FS_WIDE - sus) * e) / 64'(decay_len));
                            env_elapsed = ELAPSED_W'(e);
                        end
                    end
                    PH_SUSTAIN:
                    begin
                        // sustain holds without counting time
                        env_level = LEVEL_W'(sus);
                        if (!env_gate)
                        begin
                            env_phase = PH_RELEASE;
                            env_elapsed = '0;
                        end
                    end
                    PH_RELEASE:
                    begin
                        if (release_len <= instant_len || e >= 64'(release_len))
                        begin
                            env_level = '0;
                            env_phase = PH_IDLE;
                            env_elapsed = '0;
                        end
                        else
                        begin
                            // ramps down from sustain, not from the current level
                            env_level = LEVEL_W'((sus * (64'(release_len) - e)) / 64'(release_len));
                            env_elapsed = ELAPSED_W'(e);
                        end
                    end
                    default:
                        env_level = '0;
                endcase
            end
            OP_GATE_ON:
            begin
                env_gate = 1'b1;
                env_phase = PH_ATTACK;
                env_elapsed = '0;
            end
            OP_GATE_OFF:
            begin
                env_gate = 1'b0;
                if (env_phase != PH_IDLE)
                begin
                    env_phase = PH_RELEASE;
                    env_elapsed = '0;
                end
            end
            default:
            begin
                env_phase = PH_IDLE;
                env_level = '0;
                env_elapsed = '0;
                env_gate = 1'b0;
            end
        endcase
        envelope_q.push_back(env_point_t'{level: env_level, phase: env_phase});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len = ATTACK_RST;
            decay_len = DECAY_RST;
            sustain_cfg = SUSTAIN_RST;
            release_len = RELEASE_RST;
            instant_len = MIN_TIME_RST;
            env_phase = PH_IDLE;
            env_level = '0;
            env_elapsed = '0;
            env_gate = 1'b0;
            envelope_q.delete();
            pend_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (envelope_q.size() == 0)
                begin
                    $error("result beat with nothing expected: level %0d phase %0d",
                           level, phase_now);
                    mismatches++;
                end
                else
                begin
                    want = envelope_q.pop_front();
                    if (level !== want.level)
                    begin
                        $error("level: expected %0d, actual %0d", want.level, level);
                        mismatches++;
                    end
                    if (phase_now !== want.phase)
                    begin
                        $error("phase_now: expected %0d, actual %0d", want.phase, phase_now);
                        mismatches++;
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ATTACK:   attack_len = cfg_data[TIME_BITS-1:0];
                    CFG_DECAY:    decay_len = cfg_data[TIME_BITS-1:0];
                    CFG_SUSTAIN:  sustain_cfg = cfg_data[LEVEL_W-1:0];
                    CFG_RELEASE:  release_len = cfg_data[TIME_BITS-1:0];
                    CFG_MIN_TIME: instant_len = cfg_data[MIN_TIME_W-1:0];
                    default:      ;
                endcase
            end
            if (in_valid && !in_stall)
                step_envelope(opcode_t'(opcode), frame_count);
            pend_count <= envelope_q.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
// Testbench top: clock, reset, event stimulus, output stall pattern, watchdog and verdict.
module tb;
    import adsr_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 25;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = CFG_INDEX_W'(CFG_MIN_TIME + 1);

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             opcode;
    logic [FRAME_W-1:0]     frame_count;
    logic                   out_valid;
    logic                   out_stall;
    logic [LEVEL_W-1:0]     level;
    logic [2:0]             phase_now;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pend_count;

    bit                     calm;
    bit                     hold_req;
    int unsigned            frame_hint;
    int                     quiet_cycles = 0;

    adsr_envelope_generator_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .frame_count (frame_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .level       (level),
        .phase_now   (phase_now),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    adsr_env_checker u_env_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .frame_count (frame_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .level       (level),
        .phase_now   (phase_now),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pend_count  (pend_count)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // valid stays high across back-to-back beats, so it is only lowered ahead of a gap
    task automatic send_beat(opcode_t op, logic [FRAME_W-1:0] fc);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        frame_count <= fc;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pend_count != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic program_envelope(logic [CFG_DATA_W-1:0] atk, logic [CFG_DATA_W-1:0] dec,
                                    logic [CFG_DATA_W-1:0] sus, logic [CFG_DATA_W-1:0] rel,
                                    logic [CFG_DATA_W-1:0] min_len);
        int unsigned longest;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_ATTACK, atk);
        write_reg(CFG_DECAY, dec);
        write_reg(CFG_SUSTAIN, sus);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_MIN_TIME, min_len);
        // out-of-range index must leave every register alone
        write_reg(CFG_SPARE + CFG_INDEX_W'($urandom_range(2)), CFG_DATA_W'($urandom));
        cfg_write <= 1'b0;
        longest = atk;
        if (dec > longest)
            longest = dec;
        if (rel > longest)
            longest = rel;
        frame_hint = longest / 4;
        if (frame_hint > 65535)
            frame_hint = 65535;
        if (frame_hint == 0)
            frame_hint = 1;
    endtask

    function automatic logic [FRAME_W-1:0] pick_frames(int unsigned hint);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 15)
            return '1;
        if (roll < 35)
            return FRAME_W'($urandom);
        return FRAME_W'($urandom_range(hint));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_length();
        if ($urandom_range(99) < 15)
            return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(4000));
    endfunction

    // mostly note-shaped runs: gate on, some frames, gate off, some frames
    task automatic run_notes(int unsigned n_items);
        int unsigned sent;
        int unsigned k;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                send_beat(OP_GATE_ON, FRAME_W'($urandom));
                sent++;
                k = $urandom_range(8, 1);
                repeat (k)
                begin
                    send_beat(OP_PROCESS, pick_frames(frame_hint));
                    sent++;
                end
                if ($urandom_range(99) < 70)
                begin
                    send_beat(OP_GATE_OFF, FRAME_W'($urandom));
                    sent++;
                    k = $urandom_range(6, 1);
                    repeat (k)
                    begin
                        send_beat(OP_PROCESS, pick_frames(frame_hint));
                        sent++;
                    end
                end
                if ($urandom_range(99) < 10)
                begin
                    send_beat(OP_RESET, FRAME_W'($urandom));
                    sent++;
                end
            end
            else
            begin
                send_beat(opcode_t'($urandom_range(3)), FRAME_W'($urandom));
                sent++;
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && rst_n)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else
                out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= OP_PROCESS;
        frame_count <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_ATTACK;
        cfg_data <= '0;
        calm = 1'b0;
        hold_req = 1'b0;
        frame_hint = 3600;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk one note through every phase at the reset register values
        send_beat(OP_PROCESS, '0);
        send_beat(OP_PROCESS, '1);
        send_beat(OP_GATE_OFF, '0);
        send_beat(OP_GATE_ON, '1);
        send_beat(OP_PROCESS, '0);
        send_beat(OP_PROCESS, 16'd2400);
        send_beat(OP_PROCESS, 16'd2399);
        send_beat(OP_PROCESS, 16'd1);
        send_beat(OP_PROCESS, 16'd4800);
        send_beat(OP_PROCESS, '1);
        send_beat(OP_PROCESS, 16'd123);
        send_beat(OP_GATE_OFF, '0);
        send_beat(OP_PROCESS, 16'd7200);
        send_beat(OP_PROCESS, 16'd7199);
        send_beat(OP_PROCESS, 16'd1);
        send_beat(OP_GATE_ON, '0);
        send_beat(OP_PROCESS, 16'd1000);
        send_beat(OP_GATE_OFF, '0);
        send_beat(OP_PROCESS, 16'd500);
        send_beat(OP_RESET, '0);
        send_beat(OP_PROCESS, 16'hAAAA);
        send_beat(OP_GATE_ON, '0);
        send_beat(OP_GATE_ON, '0);
        send_beat(OP_PROCESS, 16'h5555);
        send_beat(OP_RESET, '1);

        // no idling on either side, with a full drain in the middle
        calm = 1'b1;
        program_envelope(24'd1000, 24'd2000, 24'd30000, 24'd3000, 24'd48);
        run_notes(75);
        wait_drained();
        run_notes(75);
        calm = 1'b0;

        // every length instant, sustain at zero
        program_envelope('0, '0, '0, '0, '0);
        run_notes(80);

        program_envelope('1, '1, CFG_DATA_W'(FULL_SCALE), '1, 24'hFFFF);
        run_notes(100);

        // sustain above full scale; long result hold-off while beats keep coming
        program_envelope(24'd300, 24'd500, 24'h1FFFF, 24'd700, '0);
        hold_req = 1'b1;
        run_notes(150);

        // lengths just below, at and just past the instant threshold
        program_envelope(24'd100, 24'd101, CFG_DATA_W'(FULL_SCALE), 24'd99, 24'd100);
        run_notes(100);

        program_envelope(24'd65536, 24'd65535, 24'd65535, 24'hFFFFFF, 24'hFFFF);
        run_notes(80);

        for (int p = 0; p < 4; p++)
        begin
            program_envelope(pick_length(), pick_length(), CFG_DATA_W'($urandom_range(131071)),
                             pick_length(),
                             ($urandom_range(99) < 15) ? CFG_DATA_W'($urandom_range(65535))
                                                       : CFG_DATA_W'($urandom_range(200)));
            run_notes(100);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
